/* rtl/core/vn_pkg.sv */
// -----------------------------------------------------------------------------
// vn_pkg
// Shared defaults for the vector normalizer.
// -----------------------------------------------------------------------------
package vn_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int FRAC_BITS_DEF = 14;

endpackage

/* rtl/core/vector_normalize.sv */
// -----------------------------------------------------------------------------
// vector_normalize
// Path from start to rsp_valid: magnitude, square and seed registers, the digit cells, output.
// Throughput: one vector per cycle; busy is always low, since every stage of
// the digit chain holds its own item and the receiver never stalls.
// Reset clears only the valid pipeline; data registers are not reset.
// Scales a signed 3D vector to unit length in signed Q2.14, rounded to nearest.
// -----------------------------------------------------------------------------
module vector_normalize #(
   parameter int IN_WIDTH  = vn_pkg::IN_WIDTH_DEF,
   parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [IN_WIDTH-1:0]  req_comp_x,
   input  logic signed [IN_WIDTH-1:0]  req_comp_y,
   input  logic signed [IN_WIDTH-1:0]  req_comp_z,
   output logic                        rsp_valid,
   output logic signed [FRAC_BITS+1:0] rsp_unit_x,
   output logic signed [FRAC_BITS+1:0] rsp_unit_y,
   output logic signed [FRAC_BITS+1:0] rsp_unit_z
);

   import vn_pkg::*;

   localparam int W     = IN_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int SQW   = 2 * W;
   localparam int SW    = 2 * W;
   localparam int RW    = 2 * W + 2 * F + 7;
   localparam int QW    = F + 1;
   localparam int OW    = F + 2;
   localparam int NCELL = F + 1;

   // stage 1: magnitudes
   logic          v1_ff;
   logic [W-1:0]  mag1_ff [3];
   logic [2:0]    neg1_ff;
   // stage 2: squares
   logic          v2_ff;
   logic [SQW-1:0] sq2_ff [3];
   logic [2:0]    neg2_ff;
   // stage 3: chain seed
   logic          v3_ff;
   logic [SW-1:0] sum3_ff;
   logic signed [RW-1:0] rem3_ff [3];
   logic signed [RW-1:0] acc3_ff [3];
   logic [2:0]    neg3_ff;
   logic          zero3_ff;

   logic signed [IN_WIDTH-1:0] comp [3];
   logic [SW-1:0]        sum_w;
   logic signed [RW-1:0] sum_neg;

   // side pipe along the cells
   logic       vp_ff [NCELL];
   logic [2:0] negp_ff [NCELL];
   logic       zerop_ff [NCELL];

   // chain wires: index k is the input of cell k
   logic [SW-1:0]        sum_c [3][NCELL+1];
   logic signed [RW-1:0] rem_c [3][NCELL+1];
   logic signed [RW-1:0] acc_c [3][NCELL+1];
   logic [QW-1:0]        quo_c [3][NCELL+1];

   logic          vo_ff;
   logic [OW-1:0] out_ff [3];
   logic [OW-1:0] out_in [3];
   logic [QW-1:0] qclamp [3];

   assign busy = 1'b0;
   assign comp[0] = req_comp_x;
   assign comp[1] = req_comp_y;
   assign comp[2] = req_comp_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= vp_ff[NCELL-1];
      end
   end

   always_comb begin
      sum_w   = SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);
      sum_neg = -signed'({{(RW-SW){1'b0}}, sum_w});
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg1_ff[i] <= comp[i][W-1];
         mag1_ff[i] <= comp[i][W-1] ? W'(-comp[i]) : W'(comp[i]);
         sq2_ff[i]  <= SQW'(mag1_ff[i]) * SQW'(mag1_ff[i]);
         rem3_ff[i] <= (signed'({{(RW-SQW){1'b0}}, sq2_ff[i]}) <<< (2 * F + 2)) + sum_neg;
         acc3_ff[i] <= sum_neg;
      end
      neg2_ff  <= neg1_ff;
      neg3_ff  <= neg2_ff;
      sum3_ff  <= sum_w;
      zero3_ff <= (sum_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCELL; k++) vp_ff[k] <= 1'b0;
      end else begin
         vp_ff[0] <= v3_ff;
         for (int k = 1; k < NCELL; k++) vp_ff[k] <= vp_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      negp_ff[0]  <= neg3_ff;
      zerop_ff[0] <= zero3_ff;
      for (int k = 1; k < NCELL; k++) begin
         negp_ff[k]  <= negp_ff[k-1];
         zerop_ff[k] <= zerop_ff[k-1];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_comp
      assign sum_c[c][0] = sum3_ff;
      assign rem_c[c][0] = rem3_ff[c];
      assign acc_c[c][0] = acc3_ff[c];
      assign quo_c[c][0] = '0;
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         vn_cell #(
            .SW  (SW),
            .RW  (RW),
            .QW  (QW),
            .BIT (F - k)
         ) u_cell (
            .clock   (clock),
            .sum_in  (sum_c[c][k]),
            .rem_in  (rem_c[c][k]),
            .acc_in  (acc_c[c][k]),
            .quo_in  (quo_c[c][k]),
            .sum_out (sum_c[c][k+1]),
            .rem_out (rem_c[c][k+1]),
            .acc_out (acc_c[c][k+1]),
            .quo_out (quo_c[c][k+1])
         );
      end
   end

   // clamp to 1.0, apply sign, drop for the zero vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qclamp[i] = (quo_c[i][NCELL] > (QW'(1) << F)) ? (QW'(1) << F) : quo_c[i][NCELL];
         if (zerop_ff[NCELL-1]) begin
            out_in[i] = '0;
         end else if (negp_ff[NCELL-1][i]) begin
            out_in[i] = OW'(-{1'b0, qclamp[i]});
         end else begin
            out_in[i] = OW'({1'b0, qclamp[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) out_ff[i] <= out_in[i];
   end

   assign rsp_valid  = vo_ff;
   assign rsp_unit_x = signed'(out_ff[0]);
   assign rsp_unit_y = signed'(out_ff[1]);
   assign rsp_unit_z = signed'(out_ff[2]);

endmodule

/* rtl/core/vn_cell.sv */
// -----------------------------------------------------------------------------
// vn_cell
// One digit step of the quotient search: tries one bit of the result and keeps
// it if the remainder stays non-negative.
// -----------------------------------------------------------------------------
module vn_cell #(
   parameter int SW  = 32,
   parameter int RW  = 71,
   parameter int QW  = 15,
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic [SW-1:0]        sum_in,
   input  logic signed [RW-1:0] rem_in,
   input  logic signed [RW-1:0] acc_in,
   input  logic [QW-1:0]        quo_in,
   output logic [SW-1:0]        sum_out,
   output logic signed [RW-1:0] rem_out,
   output logic signed [RW-1:0] acc_out,
   output logic [QW-1:0]        quo_out
);

   logic signed [RW-1:0] sum_ext;
   logic signed [RW-1:0] trial;
   logic signed [RW-1:0] delta;
   logic signed [RW-1:0] rem_try;
   logic                 take;

   logic [SW-1:0]        sum_ff;
   logic signed [RW-1:0] rem_ff, rem_in_nxt;
   logic signed [RW-1:0] acc_ff, acc_in_nxt;
   logic [QW-1:0]        quo_ff, quo_in_nxt;

   // remainder tracks N - (2q-1)^2 * s, accumulator tracks s * (2q-1)
   always_comb begin
      sum_ext    = signed'({{(RW-SW){1'b0}}, sum_in});
      trial      = acc_in + (sum_ext <<< BIT);
      delta      = trial <<< (BIT + 2);
      rem_try    = rem_in - delta;
      take       = ~rem_try[RW-1];
      rem_in_nxt = take ? rem_try : rem_in;
      acc_in_nxt = take ? acc_in + (sum_ext <<< (BIT + 1)) : acc_in;
      quo_in_nxt = quo_in | (QW'(take) << BIT);
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      rem_ff <= rem_in_nxt;
      acc_ff <= acc_in_nxt;
      quo_ff <= quo_in_nxt;
   end

   assign sum_out = sum_ff;
   assign rem_out = rem_ff;
   assign acc_out = acc_ff;
   assign quo_out = quo_ff;

endmodule

/* sim/vector_normalize_test.sv */
// -----------------------------------------------------------------------------
// vector_normalize_test
// Drives signed 3D vectors into the normalizer and checks each unit-length
// result against a typed value or a fixed-point predictor, with a directed
// table up front and random vectors after it.
// -----------------------------------------------------------------------------
module vector_normalize_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = vn_pkg::IN_WIDTH_DEF;
   localparam int FB = vn_pkg::FRAC_BITS_DEF;
   localparam int OW = FB + 2;
   localparam int ONE = 1 << FB;
   localparam int N_RANDOM = 1230;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic signed [IW-1:0] comp_t;
   typedef logic signed [OW-1:0] unit_t;
   typedef struct packed {
      unit_t ux;
      unit_t uy;
      unit_t uz;
   } unit_vec_t;
   typedef struct {
      comp_t cx, cy, cz;
      bit    typed;
      unit_t ex, ey, ez;
   } vec_row_t;

   logic  clock = 0;
   logic  reset = 1;
   logic  start = 0;
   comp_t req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic  busy, rsp_valid;
   unit_t rsp_unit_x, rsp_unit_y, rsp_unit_z;

   unit_vec_t pending_units[$];
   int        n_fail = 0;
   int        cycles = 0;
   bit        no_idle = 0;
   vec_row_t  rows[$];

   vector_normalize uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y), .req_comp_z(req_comp_z),
      .rsp_valid(rsp_valid),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Largest q in [0, ONE] with (2q-1)^2 * s <= (2a * 2^FB)^2.
   function automatic unit_t scale_comp(comp_t c, logic [63:0] s);
      logic [63:0]  mag, n, lo, hi, mid, d;
      logic [127:0] lim, prod;
      mag = (c < 0) ? 64'(-$signed(66'(c))) : 64'(c);
      if (s == 0) return '0;
      n = mag << (FB + 1);
      lim = 128'(n) * 128'(n);
      lo = 0;
      hi = ONE;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         d = 2 * mid - 1;
         prod = 128'(d * d) * 128'(s);
         if (prod <= lim) lo = mid;
         else hi = mid - 1;
      end
      return (c < 0) ? unit_t'(-lo) : unit_t'(lo);
   endfunction

   function automatic unit_vec_t normalize_vec(comp_t x, comp_t y, comp_t z);
      logic [63:0] s;
      unit_vec_t r;
      s = 64'($signed(x) * $signed(x)) + 64'($signed(y) * $signed(y))
        + 64'($signed(z) * $signed(z));
      r.ux = scale_comp(x, s);
      r.uy = scale_comp(y, s);
      r.uz = scale_comp(z, s);
      return r;
   endfunction

   task automatic add_row(int x, int y, int z, bit t = 0, int ex = 0, int ey = 0, int ez = 0);
      vec_row_t r;
      r.cx = comp_t'(x); r.cy = comp_t'(y); r.cz = comp_t'(z);
      r.typed = t; r.ex = unit_t'(ex); r.ey = unit_t'(ey); r.ez = unit_t'(ez);
      rows.push_back(r);
   endtask

   task automatic idle_burst();
      if (!no_idle && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) begin
            start <= 0;
            @(posedge clock);
         end
   endtask

   // Send one beat; busy is sampled at the edge that takes it.
   task automatic send_vec(comp_t x, comp_t y, comp_t z, unit_vec_t want);
      idle_burst();
      start <= 1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      do @(posedge clock); while (busy);
      pending_units.push_back(want);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_units.size() == 0) begin
            $display("%0t: result with nothing expected: %0d %0d %0d", $time,
                     rsp_unit_x, rsp_unit_y, rsp_unit_z);
            n_fail++;
         end else begin
            unit_vec_t w;
            w = pending_units.pop_front();
            if (rsp_unit_x !== w.ux) begin
               $display("%0t: unit_x expected %0d actual %0d", $time, w.ux, rsp_unit_x);
               n_fail++;
            end
            if (rsp_unit_y !== w.uy) begin
               $display("%0t: unit_y expected %0d actual %0d", $time, w.uy, rsp_unit_y);
               n_fail++;
            end
            if (rsp_unit_z !== w.uz) begin
               $display("%0t: unit_z expected %0d actual %0d", $time, w.uz, rsp_unit_z);
               n_fail++;
            end
         end
      end
   end

   initial begin
      unit_vec_t p;
      comp_t x, y, z;
      int wait_cnt;
      repeat (5) @(posedge clock);
      reset <= 0;

      // zero vector, axes at the extremes, ties and mixed signs
      add_row(0, 0, 0, 1, 0, 0, 0);
      add_row(1, 0, 0, 1, ONE, 0, 0);
      add_row(0, -1, 0, 1, 0, -ONE, 0);
      add_row(0, 0, 32767, 1, 0, 0, ONE);
      add_row(-32768, 0, 0, 1, -ONE, 0, 0);
      add_row(0, 0, -32768, 1, 0, 0, -ONE);
      add_row(0, 32767, 0, 1, 0, ONE, 0);
      add_row(3, 4, 0, 1, 9830, 13107, 0);
      add_row(-3, 0, -4, 1, -9830, 0, -13107);
      add_row(1, 1, 0);
      add_row(1, 1, 1);
      add_row(-32768, -32768, -32768);
      add_row(32767, 32767, 32767);
      add_row(32767, -32768, 32767);
      add_row(1, 32767, -32768);
      add_row(-1, -1, -1);
      add_row(2, 3, 6);
      add_row(1, 2, 2);
      add_row(21845, -21846, 12345);
      add_row(-21845, 170, -5);
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            p.ux = rows[i].ex; p.uy = rows[i].ey; p.uz = rows[i].ez;
         end else
            p = normalize_vec(rows[i].cx, rows[i].cy, rows[i].cz);
         send_vec(rows[i].cx, rows[i].cy, rows[i].cz, p);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM - 150) no_idle = 1;
         case ($urandom_range(0, 4))
            0: begin  // small vectors hit ties and coarse ratios
               x = comp_t'($signed($urandom_range(0, 16)) - 8);
               y = comp_t'($signed($urandom_range(0, 16)) - 8);
               z = comp_t'($signed($urandom_range(0, 16)) - 8);
            end
            1: begin  // up to two components dropped to zero
               x = comp_t'($urandom);
               y = $urandom_range(0, 1) ? comp_t'($urandom) : '0;
               z = $urandom_range(0, 1) ? comp_t'($urandom) : '0;
            end
            default: begin
               x = comp_t'($urandom);
               y = comp_t'($urandom);
               z = comp_t'($urandom);
            end
         endcase
         send_vec(x, y, z, normalize_vec(x, y, z));
      end
      start <= 0;

      wait_cnt = 0;
      while (pending_units.size() != 0 && wait_cnt < 1000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (FB + 10) @(posedge clock);
      if (n_fail == 0 && pending_units.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/core/vn_pkg.sv
rtl/core/vn_cell.sv
rtl/core/vector_normalize.sv
sim/vector_normalize_test.sv
